// ===== hdl/card_access_list_with_event_log_assert.svh =====
// Assertion macros for the card access block.
`ifndef CARD_ACCESS_LIST_WITH_EVENT_LOG_ASSERT_SVH
`define CARD_ACCESS_LIST_WITH_EVENT_LOG_ASSERT_SVH
`ifndef SYNTHESIS
`define CAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CAL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/cal_pkg.sv =====
package cal_pkg;
    localparam int CARD_SLOTS_DEF = 32;
    localparam int LOG_DEPTH_DEF  = 64;
    localparam int UID_W  = 32;
    localparam int TIME_W = 48;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 7;
    localparam logic [7:0] MAX_RESEND_RST = 8'd3;
    localparam logic [2:0] PACE_DIV = 3'd4;

    typedef enum logic [1:0] {
        REQ_SWIPE = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        TX_NONE = 2'd0,
        TX_SEND = 2'd1,
        TX_TIME = 2'd2
    } tx_t;
endpackage

// ===== hdl/cal_if.sv =====
interface cal_req_if
    import cal_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [UID_W-1:0]    card_id;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   expiry_time;
    logic [TIME_W-1:0]   match_time;
    modport source (output valid, req_type, card_id, now_time, expiry_time, match_time,
                    input ready);
    modport sink   (input valid, req_type, card_id, now_time, expiry_time, match_time,
                    output ready);
endinterface

interface cal_rsp_if
    import cal_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                granted;
    logic                logged;
    logic                add_ok;
    logic [SLOT_W-1:0]   slot_index;
    logic                log_removed;
    logic [1:0]          tx_action;
    logic [UID_W-1:0]    log_uid;
    logic [TIME_W-1:0]   log_time;
    logic                log_granted;
    logic [CNT_W-1:0]    log_count;
    modport source (output valid, granted, logged, add_ok, slot_index, log_removed,
                    tx_action, log_uid, log_time, log_granted, log_count, input ready);
    modport sink   (input valid, granted, logged, add_ok, slot_index, log_removed,
                    tx_action, log_uid, log_time, log_granted, log_count, output ready);
endinterface

// ===== hdl/card_access_list_with_event_log.sv =====
// Channel   | Dir | Handshake     | Carries
// req       | in  | valid/ready   | req_type, card_id, now_time, expiry_time, match_time
// rsp       | out | valid/ready   | granted .. log_count, one per request
// cfg       | in  | max_resend_we | max_resend_wd (retry limit)
// Swipe: one sweep pass over the table, then finish.
// Add: match pass, else a sweep/free pass; with a slot found, write, then sweep pass again.
// Delete and tick: read the oldest log entry.
// The card memory has one read port, one entry a cycle; each pass above reads it in turn.
// Reset clears valid bits at once; card and log memories then take a clearing pass over
// every entry before the first request is taken.
// A result waits in the output register; the next request is taken as soon as it is out.
`include "card_access_list_with_event_log_assert.svh"
module card_access_list_with_event_log
    import cal_pkg::*;
#(
    parameter int CARD_SLOTS = CARD_SLOTS_DEF,
    parameter int LOG_DEPTH  = LOG_DEPTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    cal_req_if.sink    req,
    cal_rsp_if.source  rsp,
    input  logic       max_resend_we,
    input  logic [7:0] max_resend_wd
);
    localparam int CW = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;
    localparam int LW = $clog2(LOG_DEPTH);
    localparam int FW = $clog2(LOG_DEPTH + 1);
    localparam int CLRW = (CARD_SLOTS > LOG_DEPTH) ? $clog2(CARD_SLOTS + 1)
                                                   : $clog2(LOG_DEPTH + 1);
    localparam int LOGE_W = UID_W + TIME_W + 1;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_MATCH = 9'b000000100,
        ST_SWEEP = 9'b000001000,
        ST_WRITE = 9'b000010000,
        ST_LOGRD = 9'b000100000,
        ST_LOGWT = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // pass kinds of the sweep loop
    typedef enum logic [1:0] {
        PS_GRANT = 2'd0,  // sweep and look for a live (valid, unexpired) uid match
        PS_FREE  = 2'd1,  // sweep and look for the first free slot
        PS_POST  = 2'd2   // sweep only
    } pass_t;

    // memories
    logic [UID_W+TIME_W-1:0]  card_mem [CARD_SLOTS];
    logic [LOGE_W-1:0]        log_mem  [LOG_DEPTH];
    logic [CARD_SLOTS-1:0]    card_valid_reg;

    state_t              state_reg;
    pass_t               pass_reg;
    logic [CLRW-1:0]     clr_reg;
    logic [CW:0]         idx_reg;     // read address issued
    logic                rd_vld_reg;  // card_rd holds entry rd_idx_reg
    logic [CW-1:0]       rd_idx_reg;
    logic [UID_W+TIME_W-1:0] card_rd_reg;
    logic [LOGE_W-1:0]   log_rd_reg;
    logic                hit_reg;
    logic [CW-1:0]       hit_idx_reg;

    logic [1:0]          rq_type_reg;
    logic [UID_W-1:0]    rq_uid_reg;
    logic [TIME_W-1:0]   rq_now_reg, rq_exp_reg, rq_mt_reg;

    logic [LW-1:0]       head_reg, tail_reg;
    logic [FW-1:0]       fill_reg;
    logic [2:0]          div_reg;
    logic [7:0]          retry_reg;
    logic [7:0]          max_resend_reg;

    logic                o_valid_reg;
    logic                o_granted_reg, o_logged_reg, o_add_reg, o_rem_reg;
    logic [SLOT_W-1:0]   o_slot_reg;
    logic [1:0]          o_tx_reg;

    logic                card_we, log_we;
    logic [CW-1:0]       card_wa;
    logic [LW-1:0]       log_wa;
    logic [UID_W+TIME_W-1:0] card_wd;
    logic [LOGE_W-1:0]   log_wd;
    logic [CW-1:0]       card_ra;
    logic [LW-1:0]       log_ra;

    logic [CW:0]         last_idx;
    assign last_idx = (CW+1)'(CARD_SLOTS - 1);

    assign req.ready = (state_reg == ST_IDLE) && !o_valid_reg;
    logic acc;
    assign acc = req.valid && req.ready;

    // card memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (card_we)
        begin
            card_mem[card_wa] <= card_wd;
        end
        card_rd_reg <= card_mem[card_ra];
    end

    always_ff @(posedge clk)
    begin
        if (log_we)
        begin
            log_mem[log_wa] <= log_wd;
        end
        log_rd_reg <= log_mem[log_ra];
    end

    // fields of the entry just read
    logic [UID_W-1:0]  rd_uid;
    logic [TIME_W-1:0] rd_exp;
    logic              rd_valid, rd_live;
    assign rd_uid   = card_rd_reg[UID_W+TIME_W-1:TIME_W];
    assign rd_exp   = card_rd_reg[TIME_W-1:0];
    assign rd_valid = card_valid_reg[rd_idx_reg];
    assign rd_live  = rd_valid && !(rq_now_reg > rd_exp);

    always_comb
    begin
        card_we = 1'b0;
        card_wa = clr_reg[CW-1:0];
        card_wd = '0;
        log_we  = 1'b0;
        log_wa  = clr_reg[LW-1:0];
        log_wd  = '0;
        card_ra = idx_reg[CW-1:0];
        log_ra  = tail_reg;
        if (state_reg == ST_CLEAR)
        begin
            card_we = (32'(clr_reg) < CARD_SLOTS);
            log_we  = (32'(clr_reg) < LOG_DEPTH);
        end
        else if (state_reg == ST_WRITE)
        begin
            card_we = 1'b1;
            card_wa = hit_idx_reg;
            card_wd = {rq_uid_reg, rq_exp_reg};
        end
        else if (state_reg == ST_FIN && rq_type_reg == REQ_SWIPE
                 && 32'(fill_reg) < LOG_DEPTH)
        begin
            log_we = 1'b1;
            log_wa = head_reg;
            log_wd = {rq_uid_reg, rq_now_reg, hit_reg};
        end
        else if (state_reg == ST_FIN && rq_type_reg == REQ_DEL && fill_reg != '0
                 && log_rd_reg[TIME_W:1] == rq_mt_reg)
        begin
            log_we = 1'b1;
            log_wa = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            pass_reg       <= PS_GRANT;
            clr_reg        <= '0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            card_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            div_reg        <= '0;
            retry_reg      <= '0;
            max_resend_reg <= MAX_RESEND_RST;
            o_valid_reg    <= 1'b0;
            o_granted_reg  <= 1'b0;
            o_logged_reg   <= 1'b0;
            o_add_reg      <= 1'b0;
            o_rem_reg      <= 1'b0;
            o_slot_reg     <= '0;
            o_tx_reg       <= TX_NONE;
            rq_type_reg    <= REQ_SWIPE;
            rq_uid_reg     <= '0;
            rq_now_reg     <= '0;
            rq_exp_reg     <= '0;
            rq_mt_reg      <= '0;
        end
        else
        begin
            if (max_resend_we)
            begin
                max_resend_reg <= max_resend_wd;
            end
            if (o_valid_reg && rsp.ready)
            begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) >= CARD_SLOTS - 1 && 32'(clr_reg) >= LOG_DEPTH - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        // hold the whole request for the passes that follow
                        rq_type_reg <= req.req_type;
                        rq_uid_reg  <= req.card_id;
                        rq_now_reg  <= req.now_time;
                        rq_exp_reg  <= req.expiry_time;
                        rq_mt_reg   <= req.match_time;
                        idx_reg     <= '0;
                        rd_vld_reg  <= 1'b0;
                        hit_reg     <= 1'b0;
                        hit_idx_reg <= '0;
                        o_granted_reg <= 1'b0;
                        o_logged_reg  <= 1'b0;
                        o_add_reg     <= 1'b0;
                        o_rem_reg     <= 1'b0;
                        o_slot_reg    <= '0;
                        o_tx_reg      <= TX_NONE;
                        unique case (req.req_type)
                            REQ_SWIPE:
                            begin
                                pass_reg  <= PS_GRANT;
                                state_reg <= ST_SWEEP;
                            end
                            REQ_ADD:  state_reg <= ST_MATCH;
                            default:  state_reg <= ST_LOGRD;
                        endcase
                    end
                end
                ST_MATCH:
                begin
                    // look for the first slot holding this uid, valid or not
                    if (!idx_reg[CW] && idx_reg <= last_idx)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    rd_vld_reg <= (idx_reg <= last_idx);
                    rd_idx_reg <= idx_reg[CW-1:0];
                    if (rd_vld_reg && rd_uid == rq_uid_reg)
                    begin
                        hit_idx_reg <= rd_idx_reg;
                        state_reg   <= ST_WRITE;
                    end
                    else if (rd_vld_reg && {1'b0, rd_idx_reg} == last_idx)
                    begin
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        pass_reg   <= PS_FREE;
                        state_reg  <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (idx_reg <= last_idx)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    rd_vld_reg <= (idx_reg <= last_idx);
                    rd_idx_reg <= idx_reg[CW-1:0];
                    if (rd_vld_reg)
                    begin
                        // drop expired entries
                        if (rd_valid && rq_now_reg > rd_exp)
                        begin
                            card_valid_reg[rd_idx_reg] <= 1'b0;
                        end
                        if (pass_reg == PS_GRANT && !hit_reg && rd_live
                            && rd_uid == rq_uid_reg)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (pass_reg == PS_FREE && !hit_reg && !rd_live)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                        end
                        if ({1'b0, rd_idx_reg} == last_idx)
                        begin
                            rd_vld_reg <= 1'b0;
                            idx_reg    <= '0;
                            if (pass_reg == PS_FREE)
                            begin
                                if (!hit_reg && rd_live)
                                begin
                                    state_reg <= ST_FIN;
                                end
                                else
                                begin
                                    state_reg <= ST_WRITE;
                                end
                            end
                            else
                            begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_WRITE:
                begin
                    card_valid_reg[hit_idx_reg] <= 1'b1;
                    o_add_reg  <= 1'b1;
                    o_slot_reg <= SLOT_W'(hit_idx_reg);
                    pass_reg   <= PS_POST;
                    idx_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                    state_reg  <= ST_SWEEP;
                end
                ST_LOGRD:
                begin
                    state_reg <= ST_LOGWT;
                end
                ST_LOGWT:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    case (rq_type_reg)
                        REQ_SWIPE:
                        begin
                            o_granted_reg <= hit_reg;
                            if (32'(fill_reg) < LOG_DEPTH)
                            begin
                                o_logged_reg <= 1'b1;
                                head_reg  <= (32'(head_reg) == LOG_DEPTH - 1) ? '0
                                                                             : head_reg + 1'b1;
                                fill_reg  <= fill_reg + 1'b1;
                                retry_reg <= '0;
                            end
                        end
                        REQ_DEL:
                        begin
                            if (fill_reg != '0 && log_rd_reg[TIME_W:1] == rq_mt_reg)
                            begin
                                o_rem_reg <= 1'b1;
                                tail_reg  <= (32'(tail_reg) == LOG_DEPTH - 1) ? '0
                                                                             : tail_reg + 1'b1;
                                fill_reg  <= fill_reg - 1'b1;
                                retry_reg <= '0;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (fill_reg != '0 && retry_reg <= max_resend_reg)
                            begin
                                if (div_reg + 1'b1 >= PACE_DIV)
                                begin
                                    div_reg   <= '0;
                                    o_tx_reg  <= (retry_reg == max_resend_reg) ? TX_TIME
                                                                               : TX_SEND;
                                    retry_reg <= retry_reg + 1'b1;
                                end
                                else
                                begin
                                    div_reg <= div_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // log_mem read of the new tail lands this cycle
                    state_reg <= ST_IDLE;
                    o_valid_reg <= 1'b1;
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // ST_OUT exists so the read of the new tail is issued before output
    // (log_rd_reg refreshes every cycle from tail_reg, so in ST_OUT it still holds the
    // old tail's entry; the tail set in ST_FIN shows when the response goes valid)
    logic [LOGE_W-1:0] oldest;
    assign oldest = log_rd_reg;

    assign rsp.valid       = o_valid_reg;
    assign rsp.granted     = o_granted_reg;
    assign rsp.logged      = o_logged_reg;
    assign rsp.add_ok      = o_add_reg;
    assign rsp.slot_index  = o_slot_reg;
    assign rsp.log_removed = o_rem_reg;
    assign rsp.tx_action   = o_tx_reg;
    assign rsp.log_uid     = (fill_reg != '0) ? oldest[LOGE_W-1:TIME_W+1] : '0;
    assign rsp.log_time    = (fill_reg != '0) ? oldest[TIME_W:1] : '0;
    assign rsp.log_granted = (fill_reg != '0) ? oldest[0] : 1'b0;
    assign rsp.log_count   = CNT_W'(fill_reg);

    `CAL_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, 32'(fill_reg) <= LOG_DEPTH)
    `CAL_ASSERT_IMP(a_no_accept_busy, clk, rst_n, o_valid_reg, !req.ready)
    `CAL_ASSERT_NXT(a_rsp_after_out, clk, rst_n, state_reg == ST_OUT, rsp.valid)
    `CAL_ASSERT_IMP(a_tx_only_tick, clk, rst_n, rsp.valid && rsp.tx_action != TX_NONE,
                    rq_type_reg == REQ_TICK)
endmodule

// ===== sim/tb_card_access_list_with_event_log.sv =====
`timescale 1ns / 1ps

module tb_card_access_list_with_event_log;
    import cal_pkg::*;

    // One response as the block should present it.
    typedef struct {
        bit        granted;
        bit        logged;
        bit        add_ok;
        bit [4:0]  slot_index;
        bit        log_removed;
        tx_t       tx_action;
        bit [31:0] log_uid;
        bit [47:0] log_time;
        bit        log_granted;
        bit [6:0]  log_count;
    } access_rsp_t;

    // Scoreboard: a private copy of the card table, event log and retry pacer.
    // Note each accepted request to update the copy and queue the response
    // it implies; check each delivered response against the oldest one.
    class access_scoreboard;
        bit [31:0]   card_uid[32];
        bit [47:0]   card_exp[32];
        bit          card_ok[32];
        bit [31:0]   ev_uid[64];
        bit [47:0]   ev_time[64];
        bit          ev_granted[64];
        int          head;
        int          tail;
        int          fill;
        int          pace_div;
        bit [7:0]    retries;
        bit [7:0]    retry_limit;
        access_rsp_t pending_rsp[$];
        int          errors;

        function new();
            retry_limit = MAX_RESEND_RST;
        endfunction

        function void expire_cards(bit [47:0] now);
            for (int i = 0; i < 32; i++)
                if (card_ok[i] && now > card_exp[i])
                    card_ok[i] = 0;
        endfunction

        function bit [47:0] oldest_time();
            return (fill > 0) ? ev_time[tail] : 48'd0;
        endfunction

        function void note_request(req_t kind, bit [31:0] uid, bit [47:0] now,
                                   bit [47:0] exp_t, bit [47:0] match_t);
            access_rsp_t r;
            int          slot;
            r = '{default: 0, tx_action: TX_NONE};
            slot = -1;
            case (kind)
                REQ_SWIPE: begin
                    expire_cards(now);
                    for (int i = 0; i < 32; i++)
                        if (card_uid[i] == uid && card_ok[i])
                            r.granted = 1;
                    // drop the event when the log is full
                    if (fill < 64) begin
                        ev_uid[head] = uid;
                        ev_time[head] = now;
                        ev_granted[head] = r.granted;
                        fill++;
                        head = (head + 1) % 64;
                        retries = 0;
                        r.logged = 1;
                    end
                end
                REQ_ADD: begin
                    // uid match ignores the valid bit
                    for (int i = 31; i >= 0; i--)
                        if (card_uid[i] == uid)
                            slot = i;
                    if (slot < 0) begin
                        expire_cards(now);
                        for (int i = 31; i >= 0; i--)
                            if (!card_ok[i])
                                slot = i;
                    end
                    if (slot >= 0) begin
                        card_uid[slot] = uid;
                        card_exp[slot] = exp_t;
                        card_ok[slot] = 1;
                        expire_cards(now);
                        r.add_ok = 1;
                        r.slot_index = slot[4:0];
                    end
                end
                REQ_DEL: begin
                    if (fill > 0 && ev_time[tail] == match_t) begin
                        ev_uid[tail] = 0;
                        ev_time[tail] = 0;
                        ev_granted[tail] = 0;
                        fill--;
                        tail = (tail + 1) % 64;
                        retries = 0;
                        r.log_removed = 1;
                    end
                end
                default: begin
                    if (fill > 0 && retries <= retry_limit) begin
                        pace_div++;
                        if (pace_div >= 4) begin
                            r.tx_action = (retries == retry_limit) ? TX_TIME : TX_SEND;
                            pace_div = 0;
                            retries = retries + 8'd1;
                        end
                    end
                end
            endcase
            if (fill > 0) begin
                r.log_uid = ev_uid[tail];
                r.log_time = ev_time[tail];
                r.log_granted = ev_granted[tail];
            end
            r.log_count = fill[6:0];
            pending_rsp.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(access_rsp_t got);
            access_rsp_t want;
            if (pending_rsp.size() == 0) begin
                $error("response with nothing outstanding");
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            check_field("granted", want.granted, got.granted);
            check_field("logged", want.logged, got.logged);
            check_field("add_ok", want.add_ok, got.add_ok);
            check_field("slot_index", want.slot_index, got.slot_index);
            check_field("log_removed", want.log_removed, got.log_removed);
            check_field("tx_action", want.tx_action, got.tx_action);
            check_field("log_uid", want.log_uid, got.log_uid);
            check_field("log_time", want.log_time, got.log_time);
            check_field("log_granted", want.log_granted, got.log_granted);
            check_field("log_count", want.log_count, got.log_count);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       max_resend_we;
    logic [7:0] max_resend_wd;

    cal_req_if req_if();
    cal_rsp_if rsp_if();

    card_access_list_with_event_log i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_if.sink),
        .rsp           (rsp_if.source),
        .max_resend_we (max_resend_we),
        .max_resend_wd (max_resend_wd)
    );

    access_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit [47:0]        clock_now;   // running wall time fed to the block
    bit [31:0]        uid_pool[40];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Give up after a generous fixed time; a healthy run ends far earlier.
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Response side: check whatever was accepted at this edge, then roll
    // the stall for the next cycle.
    always @(posedge clk)
    begin
        access_rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got.granted = rsp_if.granted;
            got.logged = rsp_if.logged;
            got.add_ok = rsp_if.add_ok;
            got.slot_index = rsp_if.slot_index;
            got.log_removed = rsp_if.log_removed;
            got.tx_action = tx_t'(rsp_if.tx_action);
            got.log_uid = rsp_if.log_uid;
            got.log_time = rsp_if.log_time;
            got.log_granted = rsp_if.log_granted;
            got.log_count = rsp_if.log_count;
            sb.check_response(got);
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request; hold valid high across back-to-back requests and drop
    // it only while idling, so valid never gets two updates in one step.
    task automatic send_request(req_t kind, bit [31:0] uid, bit [47:0] now,
                                bit [47:0] exp_t, bit [47:0] match_t);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= kind;
        req_if.card_id <= uid;
        req_if.now_time <= now;
        req_if.expiry_time <= exp_t;
        req_if.match_time <= match_t;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(kind, uid, now, exp_t, match_t);
    endtask

    // Hold the request side until every response is back, then let the block
    // settle before anything else touches it.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_retry_limit(bit [7:0] value);
        max_resend_we <= 1'b1;
        max_resend_wd <= value;
        @(posedge clk);
        max_resend_we <= 1'b0;
        sb.retry_limit = value;
    endtask

    // One random request. Most uids come from a pool a bit larger than the
    // table so that matches, reuse and a full table all occur; time mostly
    // moves forward so cards live for a while and then expire.
    task automatic random_request(int del_weight);
        req_t      kind;
        int        pick;
        bit [31:0] uid;
        bit [47:0] exp_t;
        bit [47:0] match_t;
        bit [47:0] now;
        pick = $urandom_range(99);
        if (pick < 40)
            kind = REQ_SWIPE;
        else if (pick < 60)
            kind = REQ_ADD;
        else if (pick < 60 + del_weight)
            kind = REQ_DEL;
        else
            kind = REQ_TICK;
        clock_now = clock_now + $urandom_range(0, 12);
        now = clock_now;
        if ($urandom_range(99) < 4)
            now = 48'({$urandom, $urandom});
        uid = ($urandom_range(9) == 0) ? $urandom : uid_pool[$urandom_range(39)];
        case ($urandom_range(9))
            0:       exp_t = 48'({$urandom, $urandom});
            1:       exp_t = clock_now - $urandom_range(0, 5);
            default: exp_t = clock_now + $urandom_range(0, 600);
        endcase
        match_t = ($urandom_range(9) < 8) ? sb.oldest_time()
                                          : 48'({$urandom, $urandom});
        send_request(kind, uid, now, exp_t, match_t);
    endtask

    task automatic run_phase(int items, int tx_pct, int rx_pct);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        for (int n = 0; n < items; n++)
            // alternate stretches that fill the log with ones that drain it
            random_request(((n / 150) % 2 == 0) ? 3 : 25);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clock_now = 48'd1000;
        rst_n = 1'b0;
        max_resend_we = 1'b0;
        max_resend_wd = 8'd0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_SWIPE;
        req_if.card_id = '0;
        req_if.now_time = '0;
        req_if.expiry_time = '0;
        req_if.match_time = '0;
        rsp_if.ready = 1'b0;
        foreach (uid_pool[i])
            uid_pool[i] = $urandom;
        uid_pool[0] = 32'h0000_0000;
        uid_pool[1] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: retry limit at its reset value of 3.
        send_request(REQ_TICK, 32'h0, 48'd0, 48'd0, 48'd0);           // tick, empty log
        send_request(REQ_DEL, 32'h0, 48'd0, 48'd0, 48'd0);            // delete, empty log
        send_request(REQ_ADD, 32'h0, 48'd10, 48'd50, 48'd0);          // uid zero reuses slot 0
        send_request(REQ_ADD, 32'hFFFF_FFFF, 48'd10, 48'hFFFF_FFFF_FFFF, 48'd0);
        send_request(REQ_SWIPE, 32'hFFFF_FFFF, 48'd0, 48'd0, 48'd0);  // granted
        send_request(REQ_SWIPE, 32'h1234_5678, 48'd20, 48'd0, 48'd0); // unknown card
        send_request(REQ_SWIPE, 32'h0, 48'd60, 48'd0, 48'd0);         // card just expired
        send_request(REQ_ADD, 32'h0, 48'd61, 48'd70, 48'd0);          // re-add same uid
        send_request(REQ_ADD, 32'hA5A5_5A5A, 48'd61, 48'd0, 48'd0);   // expires at once
        for (int k = 0; k < 9; k++)                                    // two paced sends, no time request yet
            send_request(REQ_TICK, 32'h0, 48'd62, 48'd0, 48'd0);
        send_request(REQ_DEL, 32'h0, 48'd0, 48'd0, 48'd1);            // time mismatch
        send_request(REQ_DEL, 32'h0, 48'd0, 48'd0, sb.oldest_time()); // match
        send_request(REQ_SWIPE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0);
        drain();

        // Random part in three idling modes, each under a different limit.
        write_retry_limit(8'd0);
        run_phase(600, 37, 76);
        drain();
        write_retry_limit(8'd255);
        run_phase(600, 76, 37);
        drain();
        write_retry_limit(8'd1);
        run_phase(600, 0, 0);
        drain();

        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
